[hw/rtl/lnr_pkg.sv]
// Package for the line rasterizer: field widths, register indexes, sequencer states
// and the structs that pass between its modules. No dependencies.
`timescale 1ns / 1ps

package lnr_pkg;

    localparam int COORD_W       = 6;
    localparam int VALUE_W       = 32;
    localparam int CFG_W         = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int GRID_SIZE_DEF = 64;
    localparam int S_TDATA_W     = 56;
    localparam int M_TDATA_W     = 48;

    localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(64);

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMIT
    } lnr_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] rem;
        logic [COORD_W-1:0] inc;
        logic [COORD_W-1:0] div;
    } step_in_t;

    typedef struct packed {
        logic [COORD_W-1:0] rem;
        logic               carry;
    } step_out_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [VALUE_W-1:0] value;
        logic               enable;
        logic               last;
    } pixel_t;

endpackage

[hw/rtl/lnr_step_unit.sv]
// Remainder unit of the line rasterizer: adds the minor delta to the running
// remainder and takes off the major delta once when it is reached. Uses lnr_pkg.
`timescale 1ns / 1ps

module lnr_step_unit
(
    input  lnr_pkg::step_in_t  step_in,
    output lnr_pkg::step_out_t step_out
);

    logic [lnr_pkg::COORD_W:0] sum;
    logic [lnr_pkg::COORD_W:0] diff;
    logic                      reached;

    always_comb
    begin
        sum     = {1'b0, step_in.rem} + {1'b0, step_in.inc};
        diff    = sum - {1'b0, step_in.div};
        reached = (sum >= {1'b0, step_in.div});
        step_out.carry = reached;
        step_out.rem   = reached ? diff[lnr_pkg::COORD_W-1:0] : sum[lnr_pkg::COORD_W-1:0];
    end

endmodule

[hw/rtl/lnr_seq.sv]
// Line rasterizer sequencer (uses lnr_pkg, lnr_step_unit): holds the command,
// orders the endpoints along the major axis, walks it one pixel a cycle unless stalled.
`timescale 1ns / 1ps

module lnr_seq #(
    parameter int LIM_W = lnr_pkg::CFG_W
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [lnr_pkg::COORD_W-1:0]   cmd_xa,
    input  logic [lnr_pkg::COORD_W-1:0]   cmd_ya,
    input  logic [lnr_pkg::COORD_W-1:0]   cmd_xb,
    input  logic [lnr_pkg::COORD_W-1:0]   cmd_yb,
    input  logic [lnr_pkg::VALUE_W-1:0]   cmd_value,
    input  logic [LIM_W-1:0]              width_lim,
    input  logic [LIM_W-1:0]              height_lim,
    output logic                          pix_valid,
    input  logic                          pix_ready,
    output lnr_pkg::pixel_t               pix
);

    localparam int CW = lnr_pkg::COORD_W;

    lnr_pkg::lnr_state_t state_reg, state_next;

    logic [CW-1:0]               xa_reg, ya_reg, xb_reg, yb_reg;
    logic [CW-1:0]               xa_next, ya_next, xb_next, yb_next;
    logic [lnr_pkg::VALUE_W-1:0] value_reg, value_next;
    logic                        x_major_reg, x_major_next;
    logic                        neg_reg, neg_next;
    logic [CW-1:0]               maj0_reg, maj0_next;
    logic [CW-1:0]               min0_reg, min0_next;
    logic [CW-1:0]               maj_d_reg, maj_d_next;
    logic [CW-1:0]               min_abs_reg, min_abs_next;
    logic [CW-1:0]               k_reg, k_next;
    logic [CW-1:0]               q_reg, q_next;
    logic [CW-1:0]               rem_reg, rem_next;
    lnr_pkg::pixel_t             pix_reg, pix_next;

    logic [CW:0]   dx, dy, adx, ady, min_d;
    logic          x_major, swap;
    logic [CW-1:0] s_maj0, s_min0, s_maj_d, s_min_abs;
    logic [CW-1:0] major, minor, px, py;
    logic          last;

    lnr_pkg::step_in_t  step_in;
    lnr_pkg::step_out_t step_out;

    lnr_step_unit u_step
    (
        .step_in  (step_in),
        .step_out (step_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lnr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xa_reg      <= xa_next;
        ya_reg      <= ya_next;
        xb_reg      <= xb_next;
        yb_reg      <= yb_next;
        value_reg   <= value_next;
        x_major_reg <= x_major_next;
        neg_reg     <= neg_next;
        maj0_reg    <= maj0_next;
        min0_reg    <= min0_next;
        maj_d_reg   <= maj_d_next;
        min_abs_reg <= min_abs_next;
        k_reg       <= k_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        pix_reg     <= pix_next;
    end

    always_comb
    begin
        dx  = {1'b0, xb_reg} - {1'b0, xa_reg};
        dy  = {1'b0, yb_reg} - {1'b0, ya_reg};
        adx = dx[CW] ? -dx : dx;
        ady = dy[CW] ? -dy : dy;
        x_major = (adx > ady);
        if (x_major)
        begin
            swap      = (xa_reg > xb_reg);
            s_maj0    = swap ? xb_reg : xa_reg;
            s_min0    = swap ? yb_reg : ya_reg;
            s_maj_d   = adx[CW-1:0];
            s_min_abs = ady[CW-1:0];
            min_d     = swap ? -dy : dy;
        end
        else
        begin
            swap      = (ya_reg > yb_reg);
            s_maj0    = swap ? yb_reg : ya_reg;
            s_min0    = swap ? xb_reg : xa_reg;
            s_maj_d   = ady[CW-1:0];
            s_min_abs = adx[CW-1:0];
            min_d     = swap ? -dx : dx;
        end

        step_in.rem = rem_reg;
        step_in.inc = min_abs_reg;
        step_in.div = maj_d_reg;

        state_next   = state_reg;
        xa_next      = xa_reg;
        ya_next      = ya_reg;
        xb_next      = xb_reg;
        yb_next      = yb_reg;
        value_next   = value_reg;
        x_major_next = x_major_reg;
        neg_next     = neg_reg;
        maj0_next    = maj0_reg;
        min0_next    = min0_reg;
        maj_d_next   = maj_d_reg;
        min_abs_next = min_abs_reg;
        k_next       = k_reg;
        q_next       = q_reg;
        rem_next     = rem_reg;
        pix_next     = pix_reg;
        major        = maj0_reg;
        minor        = min0_reg;
        last         = 1'b0;
        px           = major;
        py           = minor;

        unique case (state_reg)
            lnr_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    xa_next    = cmd_xa;
                    ya_next    = cmd_ya;
                    xb_next    = cmd_xb;
                    yb_next    = cmd_yb;
                    value_next = cmd_value;
                    state_next = lnr_pkg::ST_SETUP;
                end
            end
            lnr_pkg::ST_SETUP:
            begin
                x_major_next = x_major;
                neg_next     = min_d[CW];
                maj0_next    = s_maj0;
                min0_next    = s_min0;
                maj_d_next   = s_maj_d;
                min_abs_next = s_min_abs;
                k_next       = '0;
                q_next       = '0;
                rem_next     = '0;
                major        = s_maj0;
                minor        = s_min0;
                last         = (s_maj_d == '0);
                px           = x_major ? major : minor;
                py           = x_major ? minor : major;
                pix_next.x      = px;
                pix_next.y      = py;
                pix_next.value  = value_reg;
                pix_next.last   = last;
                pix_next.enable = (LIM_W'(px) < width_lim) && (LIM_W'(py) < height_lim);
                state_next   = lnr_pkg::ST_EMIT;
            end
            lnr_pkg::ST_EMIT:
            begin
                if (pix_ready)
                begin
                    if (pix_reg.last)
                    begin
                        state_next = lnr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next   = k_reg + 1'b1;
                        q_next   = q_reg + CW'(step_out.carry);
                        rem_next = step_out.rem;
                        major    = maj0_reg + k_next;
                        minor    = neg_reg ? (min0_reg - q_next) : (min0_reg + q_next);
                        last     = (k_next == maj_d_reg);
                        px       = x_major_reg ? major : minor;
                        py       = x_major_reg ? minor : major;
                        pix_next.x      = px;
                        pix_next.y      = py;
                        pix_next.value  = value_reg;
                        pix_next.last   = last;
                        pix_next.enable = (LIM_W'(px) < width_lim) &&
                                          (LIM_W'(py) < height_lim);
                    end
                end
            end
            default:
            begin
                state_next = lnr_pkg::ST_IDLE;
            end
        endcase
    end

    assign cmd_ready = (state_reg == lnr_pkg::ST_IDLE);
    assign pix_valid = (state_reg == lnr_pkg::ST_EMIT);
    assign pix       = pix_reg;

endmodule

[hw/rtl/line_rasterizer.sv]
// Top level of the line rasterizer: stream ports, clipping registers and the
// sequencer that walks each line. Uses lnr_pkg and lnr_seq.
`timescale 1ns / 1ps

// Each line item is accepted in the idle state and then passes a set-up state in which
// the endpoints are ordered along the major axis; it then emits one pixel a cycle while
// the output is taken, 1 to 64 pixels per line. A single remainder adder steps the
// minor coordinate once per pixel. The input is not ready until the last pixel of
// the current line has been taken.

module line_rasterizer #(
    parameter int GRID_SIZE = lnr_pkg::GRID_SIZE_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Fields from bit 0: x_start, y_start, x_end, y_end, pixel_value.
    input  logic [lnr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: pixel_x, pixel_y, write_value, four zero bits.
    output logic [lnr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // Field: write_enable.
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lnr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lnr_pkg::CFG_W-1:0]       cfg_data
);

    localparam int SIZE_W = $clog2(GRID_SIZE + 1);
    localparam int LIM_W  = (SIZE_W > lnr_pkg::CFG_W) ? SIZE_W : lnr_pkg::CFG_W;
    localparam int CW     = lnr_pkg::COORD_W;
    localparam int PAD_W  = lnr_pkg::M_TDATA_W - 2 * CW - lnr_pkg::VALUE_W;

    logic [lnr_pkg::CFG_W-1:0] grid_width_reg, grid_height_reg;
    logic [LIM_W-1:0]          width_lim, height_lim;
    lnr_pkg::pixel_t           pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= lnr_pkg::GRID_RESET;
            grid_height_reg <= lnr_pkg::GRID_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lnr_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                lnr_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_lim  = (LIM_W'(grid_width_reg) > LIM_W'(GRID_SIZE)) ?
                     LIM_W'(GRID_SIZE) : LIM_W'(grid_width_reg);
        height_lim = (LIM_W'(grid_height_reg) > LIM_W'(GRID_SIZE)) ?
                     LIM_W'(GRID_SIZE) : LIM_W'(grid_height_reg);
    end

    lnr_seq #(
        .LIM_W (LIM_W)
    ) u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (s_axis_tvalid),
        .cmd_ready  (s_axis_tready),
        .cmd_xa     (s_axis_tdata[CW-1:0]),
        .cmd_ya     (s_axis_tdata[2*CW-1:CW]),
        .cmd_xb     (s_axis_tdata[3*CW-1:2*CW]),
        .cmd_yb     (s_axis_tdata[4*CW-1:3*CW]),
        .cmd_value  (s_axis_tdata[4*CW+lnr_pkg::VALUE_W-1:4*CW]),
        .width_lim  (width_lim),
        .height_lim (height_lim),
        .pix_valid  (m_axis_tvalid),
        .pix_ready  (m_axis_tready),
        .pix        (pix)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, pix.value, pix.y, pix.x};
    assign m_axis_tuser = pix.enable;
    assign m_axis_tlast = pix.last;

endmodule

[hw/rtl/lnr_checker.sv]
// Port-level checks for the line rasterizer, bound to the top level.
// Uses lnr_pkg for port widths.
`timescale 1ns / 1ps

module lnr_port_checks
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [lnr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready
);

    // The block never takes a new line while pixels of the current one are pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a pixel is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && !m_axis_tvalid))
        else $error("block not busy in the set-up cycle");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (s_axis_tready && !m_axis_tvalid))
        else $error("block not idle after the last pixel");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
             $stable(m_axis_tlast)))
        else $error("stalled pixel changed");

endmodule

bind line_rasterizer lnr_port_checks u_lnr_port_checks
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

[dv/lnr_checker.sv]
// Checker for the line rasterizer: watches the register, line and pixel channels,
// traces every accepted line into the pixels it must produce and compares them.
// Depends on lnr_pkg.
`timescale 1ns / 1ps

module lnr_checker #(
    parameter int GRID_SIZE = lnr_pkg::GRID_SIZE_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [lnr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [lnr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                            m_axis_tuser,
    input  logic                            m_axis_tlast,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lnr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lnr_pkg::CFG_W-1:0]       cfg_data,
    output int                              fail_count,
    output int                              pixels_owed
);

    import lnr_pkg::*;

    localparam int X_LO = 0;
    localparam int Y_LO = COORD_W;
    localparam int V_LO = 2 * COORD_W;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pixel_t           owed_pixels[$];

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic trace_line(input logic [S_TDATA_W-1:0] cmd);
        int     xa;
        int     ya;
        int     xb;
        int     yb;
        int     maj0;
        int     min0;
        int     maj_d;
        int     min_d;
        int     prod;
        int     quot;
        int     minor;
        int     px;
        int     py;
        int     wlim;
        int     hlim;
        int     k;
        bit     x_major;
        pixel_t pix;

        xa = int'(cmd[0 +: COORD_W]);
        ya = int'(cmd[COORD_W +: COORD_W]);
        xb = int'(cmd[2 * COORD_W +: COORD_W]);
        yb = int'(cmd[3 * COORD_W +: COORD_W]);
        wlim = (int'(width_reg) > GRID_SIZE) ? GRID_SIZE : int'(width_reg);
        hlim = (int'(height_reg) > GRID_SIZE) ? GRID_SIZE : int'(height_reg);

        // Ties go to the y axis; the walk always runs up the major axis.
        x_major = magnitude(xb - xa) > magnitude(yb - ya);
        if (x_major)
        begin
            if (xa > xb)
            begin
                maj0 = xb; min0 = yb; maj_d = xa - xb; min_d = ya - yb;
            end
            else
            begin
                maj0 = xa; min0 = ya; maj_d = xb - xa; min_d = yb - ya;
            end
        end
        else
        begin
            if (ya > yb)
            begin
                maj0 = yb; min0 = xb; maj_d = ya - yb; min_d = xa - xb;
            end
            else
            begin
                maj0 = ya; min0 = xa; maj_d = yb - ya; min_d = xb - xa;
            end
        end

        for (k = 0; k <= maj_d; k++)
        begin
            minor = min0;
            if (maj_d != 0)
            begin
                prod  = min_d * k;
                quot  = magnitude(prod) / maj_d;
                minor = min0 + ((prod < 0) ? -quot : quot);
            end
            px = x_major ? maj0 + k : minor;
            py = x_major ? minor : maj0 + k;
            pix.x      = px[COORD_W-1:0];
            pix.y      = py[COORD_W-1:0];
            pix.value  = cmd[4 * COORD_W +: VALUE_W];
            pix.enable = (px < wlim) && (py < hlim);
            pix.last   = (k == maj_d);
            owed_pixels.push_back(pix);
        end
    endtask

    task automatic check_pixel();
        pixel_t want;

        if (owed_pixels.size() == 0)
        begin
            report_mismatch("pixel arrived with no line outstanding");
            return;
        end
        want = owed_pixels.pop_front();
        if (m_axis_tdata[X_LO +: COORD_W] !== want.x)
            report_mismatch($sformatf("pixel_x got %0d want %0d",
                                      m_axis_tdata[X_LO +: COORD_W], want.x));
        if (m_axis_tdata[Y_LO +: COORD_W] !== want.y)
            report_mismatch($sformatf("pixel_y got %0d want %0d",
                                      m_axis_tdata[Y_LO +: COORD_W], want.y));
        if (m_axis_tdata[V_LO +: VALUE_W] !== want.value)
            report_mismatch($sformatf("write_value got %h want %h",
                                      m_axis_tdata[V_LO +: VALUE_W], want.value));
        if (m_axis_tuser !== want.enable)
            report_mismatch($sformatf("write_enable got %b want %b at (%0d,%0d)",
                                      m_axis_tuser, want.enable, want.x, want.y));
        if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("last_pixel got %b want %b at (%0d,%0d)",
                                      m_axis_tlast, want.last, want.x, want.y));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = GRID_RESET;
            height_reg = GRID_RESET;
            owed_pixels.delete();
            pixels_owed = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GRID_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_GRID_HEIGHT)
                    height_reg = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                trace_line(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_pixel();
            pixels_owed = owed_pixels.size();
        end
    end

endmodule

[dv/tb_line_rasterizer.sv]
// Testbench top for the line rasterizer: clock, reset, line and register stimulus
// with random idling on both streams, and the final verdict. Uses lnr_pkg and lnr_checker.
`timescale 1ns / 1ps

module tb_line_rasterizer;

    import lnr_pkg::*;

    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 80;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 47;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = CFG_IDX_W'(3);

    logic                   clk;
    logic                   rst_n;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    int fail_count;
    int pixels_owed;
    bit send_quiet;
    bit take_quiet;
    bit hold_request;
    bit hold_taken;

    line_rasterizer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    lnr_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pixels_owed   (pixels_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap(input bit quiet);
        int roll;

        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_line(input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
                             input logic [COORD_W-1:0] xe, input logic [COORD_W-1:0] ye,
                             input logic [VALUE_W-1:0] value);
        int gap;

        gap = pick_gap(send_quiet);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, ye, xe, ys, xs};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_random_line();
        int xs;
        int ys;
        int xe;
        int ye;
        int d;
        int style;

        xs = $urandom_range(0, 63);
        ys = $urandom_range(0, 63);
        xe = $urandom_range(0, 63);
        ye = $urandom_range(0, 63);
        style = $urandom_range(0, 9);
        if (style < 4)
        begin
            xe = $urandom_range((xs > 4) ? xs - 4 : 0, (xs < 59) ? xs + 4 : 63);
            ye = $urandom_range((ys > 4) ? ys - 4 : 0, (ys < 59) ? ys + 4 : 63);
        end
        else if (style < 6)
        begin
            if ($urandom_range(0, 1) == 1)
                ye = ys;
            else
                xe = xs;
        end
        else if (style < 7)
        begin
            d  = (xe > xs) ? xe - xs : xs - xe;
            ys = $urandom_range(0, 63 - d);
            ye = ys + d;
            if ($urandom_range(0, 1) == 1)
            begin
                ye = ys;
                ys = ys + d;
            end
        end
        send_line(COORD_W'(xs), COORD_W'(ys), COORD_W'(xe), COORD_W'(ye), $urandom);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pixels_owed != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure_grid(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
                                  input bit spare);
        wait_drained();
        if (spare)
        begin
            write_reg(REG_SPARE_LOW, CFG_W'($urandom));
            write_reg(REG_SPARE_HIGH, CFG_W'($urandom));
        end
        write_reg(REG_GRID_WIDTH, width);
        write_reg(REG_GRID_HEIGHT, height);
        cfg_valid <= 1'b0;
    endtask

    // Output side: random back-pressure, one long hold-off when asked for.
    initial
    begin
        int gap;

        m_axis_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_taken)
            begin
                gap = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            else
            begin
                gap = pick_gap(take_quiet);
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    initial
    begin
        int phase;
        int n;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_GRID_WIDTH;
        cfg_data      = '0;
        send_quiet    = 1'b0;
        take_quiet    = 1'b0;
        hold_request  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines under the reset grid.
        send_line(0, 0, 0, 0, 32'h0000_0000);
        send_line(63, 63, 63, 63, 32'hFFFF_FFFF);
        send_line(0, 5, 63, 5, 32'h5555_5555);
        send_line(63, 7, 0, 7, 32'hAAAA_AAAA);
        send_line(9, 0, 9, 63, 32'h1234_5678);
        send_line(40, 63, 40, 0, 32'h8765_4321);
        send_line(0, 0, 63, 63, 32'hDEAD_BEEF);
        send_line(63, 63, 0, 0, 32'h0F0F_0F0F);
        send_line(63, 0, 0, 63, 32'hF0F0_F0F0);
        send_line(0, 40, 63, 10, 32'h0000_0001);
        send_line(63, 10, 0, 40, 32'h8000_0000);
        send_line(50, 0, 3, 63, 32'h7FFF_FFFF);
        send_line(3, 63, 50, 0, 32'hFFFF_FFFE);
        send_line(10, 20, 13, 21, 32'h0000_FFFF);
        send_line(13, 21, 10, 20, 32'hFFFF_0000);
        send_line(20, 30, 21, 27, 32'h0101_0101);
        send_line(21, 27, 20, 30, 32'hFEFE_FEFE);
        send_line(62, 1, 63, 0, 32'h3C3C_3C3C);
        send_line(30, 30, 31, 30, 32'hC3C3_C3C3);
        send_line(30, 31, 30, 30, 32'h9999_9999);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: configure_grid(64, 64, 1'b0);
                1: configure_grid(1, 64, 1'b0);
                2: configure_grid(0, 0, 1'b0);
                3: configure_grid(127, 65, 1'b0);
                4: configure_grid(CFG_W'($urandom_range(1, 64)),
                                  CFG_W'($urandom_range(1, 64)), 1'b1);
                5: configure_grid(64, 1, 1'b0);
                default: configure_grid(CFG_W'($urandom_range(0, 127)),
                                        CFG_W'($urandom_range(0, 127)), 1'b1);
            endcase
            send_quiet = (phase == 2) || (phase == 5);
            take_quiet = (phase == 2) || (phase == 4);
            if (phase == 1)
                hold_request = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_line();
        end

        wait_drained();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/lnr_pkg.sv
hw/rtl/lnr_step_unit.sv
hw/rtl/lnr_seq.sv
hw/rtl/line_rasterizer.sv
hw/rtl/lnr_checker.sv
dv/lnr_checker.sv
dv/tb_line_rasterizer.sv
